FILE: hw/rtl/fbfl_pkg.sv
// Shared types and constants for the fixed block free list allocator.
// Holds the request/response words, the config view and the sequencer states.
// No dependencies.
package fbfl_pkg;

  localparam int IDX_W      = 10;
  localparam int CNT_W      = 11;
  localparam int BYTES_W    = 13;
  localparam int OFF_W      = 23;
  localparam int STRIDE_W   = 14;
  localparam int STATUS_W   = 2;
  localparam int APB_AW     = 3;
  localparam int APB_DW     = 32;
  localparam int INDEX_LIMIT = 1024;

  localparam int DEF_MAX_BLOCKS = 1024;
  localparam int DEF_WORD_BYTES = 8;

  localparam logic [CNT_W-1:0]   NIL_CODE        = CNT_W'(1024);
  localparam logic [CNT_W-1:0]   RST_BLOCK_COUNT = CNT_W'(1024);
  localparam logic [BYTES_W-1:0] RST_BLOCK_BYTES = BYTES_W'(64);

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

  localparam logic REG_BLOCK_COUNT = 1'b0;
  localparam logic REG_BLOCK_BYTES = 1'b1;

  typedef struct packed {
    logic             action;
    logic [IDX_W-1:0] block_index;
  } fbfl_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [IDX_W-1:0]    granted_index;
    logic [OFF_W-1:0]    data_offset;
  } fbfl_rsp_t;

  typedef struct packed {
    logic [BYTES_W-1:0] block_bytes;
    logic [CNT_W-1:0]   pool_blocks;
    logic               count_wr;
    logic [CNT_W-1:0]   new_pool;
  } fbfl_cfg_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP,
    S_MUL,
    S_PUT
  } fbfl_state_t;

endpackage

FILE: hw/rtl/fbfl_cfg_regs.sv
// APB register file: block_count and block_bytes, plus the clipped pool size.
// Depends on fbfl_pkg.
module fbfl_cfg_regs
  import fbfl_pkg::*;
#(
  parameter int MAX_BLOCKS = DEF_MAX_BLOCKS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output fbfl_cfg_t         cfg
);

  localparam int POOL_MAX = (MAX_BLOCKS < INDEX_LIMIT) ? MAX_BLOCKS : INDEX_LIMIT;
  localparam logic [CNT_W-1:0] POOL_MAX_C = CNT_W'(POOL_MAX);

  logic [CNT_W-1:0]   block_count_r, block_count_nxt;
  logic [BYTES_W-1:0] block_bytes_r, block_bytes_nxt;
  logic [CNT_W-1:0]   pool_blocks_r, pool_blocks_nxt;
  logic               wr;
  logic [CNT_W-1:0]   wr_count;
  logic [CNT_W-1:0]   clipped;

  assign wr       = psel & penable & pwrite;
  assign wr_count = pwdata[CNT_W-1:0];
  assign clipped  = (wr_count > POOL_MAX_C) ? POOL_MAX_C : wr_count;
  assign pready   = 1'b1;

  always_comb begin
    block_count_nxt = block_count_r;
    block_bytes_nxt = block_bytes_r;
    pool_blocks_nxt = pool_blocks_r;
    if (wr) begin
      unique case (paddr[2])
        REG_BLOCK_COUNT: begin
          block_count_nxt = wr_count;
          pool_blocks_nxt = clipped;
        end
        REG_BLOCK_BYTES: block_bytes_nxt = pwdata[BYTES_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_count_r <= RST_BLOCK_COUNT;
      block_bytes_r <= RST_BLOCK_BYTES;
      pool_blocks_r <= (RST_BLOCK_COUNT > POOL_MAX_C) ? POOL_MAX_C : RST_BLOCK_COUNT;
    end else begin
      block_count_r <= block_count_nxt;
      block_bytes_r <= block_bytes_nxt;
      pool_blocks_r <= pool_blocks_nxt;
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_BLOCK_COUNT: prdata = APB_DW'(block_count_r);
      REG_BLOCK_BYTES: prdata = APB_DW'(block_bytes_r);
      default:         prdata = '0;
    endcase
  end

  assign cfg.block_bytes = block_bytes_r;
  assign cfg.pool_blocks = pool_blocks_r;
  assign cfg.count_wr    = wr & (paddr[2] == REG_BLOCK_COUNT);
  assign cfg.new_pool    = clipped;

endmodule

FILE: hw/rtl/fbfl_link_ram.sv
// Link memory: one next-pointer per block, one write and one registered read port.
// No dependencies.
module fbfl_link_ram #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int DW    = 11
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: hw/rtl/fbfl_offset.sv
// Offset unit: registered index * stride product, plus the header word.
// Depends on fbfl_pkg.
module fbfl_offset
  import fbfl_pkg::*;
#(
  parameter int WORD_BYTES = DEF_WORD_BYTES
) (
  input  logic               clk,
  input  logic               start,
  input  logic [IDX_W-1:0]   index,
  input  logic [BYTES_W-1:0] block_bytes,
  output logic [OFF_W-1:0]   offset
);

  localparam int PROD_W = STRIDE_W + IDX_W;
  localparam logic [STRIDE_W-1:0] WMASK = STRIDE_W'(WORD_BYTES - 1);

  logic [STRIDE_W-1:0] rounded;
  logic [STRIDE_W-1:0] stride;
  logic [PROD_W-1:0]   product_r;
  logic [PROD_W-1:0]   sum;

  assign rounded = (STRIDE_W'(block_bytes) + WMASK) & ~WMASK;
  assign stride  = rounded + STRIDE_W'(WORD_BYTES);

  always_ff @(posedge clk) begin
    if (start) begin
      product_r <= PROD_W'(index) * PROD_W'(stride);
    end
  end

  assign sum    = product_r + PROD_W'(WORD_BYTES);
  assign offset = sum[OFF_W-1:0];

endmodule

FILE: hw/rtl/fixed_block_free_list_allocator.sv
// Fixed-size block pool allocator, LIFO free list kept in a link memory.
// Depends on fbfl_pkg, fbfl_cfg_regs, fbfl_link_ram and fbfl_offset.
//
// Usage:
//   in_valid/in_ready/in_data carry one request word: allocate (action 0)
//   or free (action 1) of block_index. out_valid/out_ready/out_data carry
//   one response word per request: status, granted_index, data_offset.
//   The APB port writes block_count (0x0) and block_bytes (0x4); writing
//   block_count empties the free list. Write config only while idle.
// Timing:
//   One request at a time: in_ready is high only in S_IDLE, so the next
//   request is taken only after S_PUT has loaded the response. Steps:
//     free or error            S_PUT
//     allocate of fresh block  S_MUL (registered multiply), S_PUT
//     allocate from free list  S_POP (link memory read), S_MUL, S_PUT
//   out_valid rises when S_PUT loads the output register.
// Reset:
//   Free list empty, all blocks fresh, block_count 1024, block_bytes 64.
//   The link memory is not cleared; entries are read only after written.
// Stall:
//   A response waits in the output register; the next request is taken
//   meanwhile and holds in the final step until out_ready frees the slot.
module fixed_block_free_list_allocator
  import fbfl_pkg::*;
#(
  parameter int MAX_BLOCKS = DEF_MAX_BLOCKS,
  parameter int WORD_BYTES = DEF_WORD_BYTES
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  fbfl_req_t         in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output fbfl_rsp_t         out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  localparam int LINK_DEPTH = (MAX_BLOCKS < INDEX_LIMIT) ? MAX_BLOCKS : INDEX_LIMIT;
  localparam int LINK_AW    = (LINK_DEPTH > 1) ? $clog2(LINK_DEPTH) : 1;
  localparam logic [CNT_W-1:0] RST_POOL =
    (RST_BLOCK_COUNT > CNT_W'(LINK_DEPTH)) ? CNT_W'(LINK_DEPTH) : RST_BLOCK_COUNT;

  fbfl_cfg_t   cfg;
  fbfl_state_t state_r, state_nxt;

  logic [CNT_W-1:0]    head_r, head_nxt;
  logic [CNT_W-1:0]    untouched_r, untouched_nxt;
  logic [IDX_W-1:0]    granted_r, granted_nxt;
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic                alloc_ok_r, alloc_ok_nxt;
  logic                out_valid_r, out_valid_nxt;
  fbfl_rsp_t           out_data_r, out_data_nxt;

  logic                mem_we, mem_re;
  logic [LINK_AW-1:0]  mem_waddr, mem_raddr;
  logic [CNT_W-1:0]    mem_rdata;
  logic [OFF_W-1:0]    offset;
  logic                accept;
  logic                out_load;

  fbfl_cfg_regs #(.MAX_BLOCKS(MAX_BLOCKS)) u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  fbfl_link_ram #(.DEPTH(LINK_DEPTH), .AW(LINK_AW), .DW(CNT_W)) u_link (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (head_r),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  fbfl_offset #(.WORD_BYTES(WORD_BYTES)) u_offset (
    .clk         (clk),
    .start       (state_r == S_MUL),
    .index       (granted_r),
    .block_bytes (cfg.block_bytes),
    .offset      (offset)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid & in_ready;
  assign mem_waddr = in_data.block_index[LINK_AW-1:0];
  assign mem_raddr = head_r[LINK_AW-1:0];

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    untouched_nxt = untouched_r;
    granted_nxt   = granted_r;
    status_nxt    = status_r;
    alloc_ok_nxt  = alloc_ok_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    out_data_nxt  = out_data_r;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    out_load      = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          granted_nxt  = '0;
          status_nxt   = ST_OK;
          alloc_ok_nxt = 1'b0;
          if (in_data.action == ACT_FREE) begin
            state_nxt = S_PUT;
            if (CNT_W'(in_data.block_index) >= cfg.pool_blocks) begin
              status_nxt = ST_RANGE;
            end else begin
              mem_we   = 1'b1;
              head_nxt = CNT_W'(in_data.block_index);
            end
          end else if (head_r != NIL_CODE) begin
            mem_re       = 1'b1;
            granted_nxt  = head_r[IDX_W-1:0];
            alloc_ok_nxt = 1'b1;
            state_nxt    = S_POP;
          end else if (untouched_r != '0) begin
            untouched_nxt = untouched_r - CNT_W'(1);
            granted_nxt   = untouched_nxt[IDX_W-1:0];
            alloc_ok_nxt  = 1'b1;
            state_nxt     = S_MUL;
          end else begin
            status_nxt = ST_EMPTY;
            state_nxt  = S_PUT;
          end
        end
      end
      S_POP: begin
        head_nxt  = mem_rdata;
        state_nxt = S_MUL;
      end
      S_MUL: state_nxt = S_PUT;
      S_PUT: begin
        if (!out_valid_r || out_ready) begin
          out_load                   = 1'b1;
          out_valid_nxt              = 1'b1;
          out_data_nxt.status        = status_r;
          out_data_nxt.granted_index = alloc_ok_r ? granted_r : '0;
          out_data_nxt.data_offset   = alloc_ok_r ? offset : '0;
          state_nxt                  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (cfg.count_wr) begin
      head_nxt      = NIL_CODE;
      untouched_nxt = cfg.new_pool;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= NIL_CODE;
      untouched_r <= RST_POOL;
      out_valid_r <= 1'b0;
      alloc_ok_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      untouched_r <= untouched_nxt;
      out_valid_r <= out_valid_nxt;
      alloc_ok_r  <= alloc_ok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    granted_r  <= granted_nxt;
    status_r   <= status_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_head_in_pool: assert property (@(posedge clk) disable iff (!rst_n)
    (head_r != NIL_CODE) |-> (head_r < cfg.pool_blocks))
    else $error("free list head outside pool");

  a_untouched_bound: assert property (@(posedge clk) disable iff (!rst_n)
    untouched_r <= cfg.pool_blocks)
    else $error("fresh block count exceeds pool size");

  a_grant_in_pool: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && alloc_ok_r) |-> (CNT_W'(granted_r) < cfg.pool_blocks))
    else $error("granted block outside pool");

  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.status != ST_OK) |->
      (out_data_r.granted_index == '0 && out_data_r.data_offset == '0))
    else $error("error response carries a block");

  a_pop_to_mul: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_POP) |=> (state_r == S_MUL && head_r == $past(mem_rdata)))
    else $error("pop did not advance the head");

endmodule

FILE: verif/fbfl_grant_checker.sv
// Grant checker for the fixed block free list allocator: watches the request,
// response and APB channels, predicts each response word and compares it.
// Depends on fbfl_pkg.
module fbfl_grant_checker
  import fbfl_pkg::*;
#(
  parameter int MAX_BLOCKS = DEF_MAX_BLOCKS,
  parameter int WORD_BYTES = DEF_WORD_BYTES
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  fbfl_req_t         in_data,
  input  logic              out_valid,
  input  logic              out_ready,
  input  fbfl_rsp_t         out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output int                fail_count,
  output int                pending,
  output int                grants,
  output int                empties,
  output int                rejects,
  output int                frees
);

  logic [CNT_W-1:0]   head;
  logic [CNT_W-1:0]   fresh_left;
  logic [CNT_W-1:0]   pool_n;
  logic [BYTES_W-1:0] blk_bytes;
  logic [CNT_W-1:0]   links [MAX_BLOCKS];
  fbfl_rsp_t          grant_q [$];

  initial begin
    fail_count = 0;
    pending    = 0;
    grants     = 0;
    empties    = 0;
    rejects    = 0;
    frees      = 0;
  end

  function automatic logic [CNT_W-1:0] clip_count(logic [CNT_W-1:0] n);
    int lim;
    lim = (MAX_BLOCKS < INDEX_LIMIT) ? MAX_BLOCKS : INDEX_LIMIT;
    return (int'(n) > lim) ? CNT_W'(lim) : n;
  endfunction

  function automatic fbfl_rsp_t next_grant(fbfl_req_t req);
    fbfl_rsp_t   rsp;
    logic [31:0] grant;
    logic [31:0] stride;
    rsp   = '0;
    grant = '0;
    if (req.action == ACT_ALLOC) begin
      if (head < INDEX_LIMIT && head < MAX_BLOCKS) begin
        grant = 32'(head);
        head  = links[head[IDX_W-1:0]];
      end else if (fresh_left != '0) begin
        fresh_left = fresh_left - 1'b1;
        grant      = 32'(fresh_left);
      end else begin
        rsp.status = ST_EMPTY;
      end
      if (rsp.status == ST_OK) begin
        stride = ((32'(blk_bytes) + 32'(WORD_BYTES - 1)) & ~32'(WORD_BYTES - 1))
                 + 32'(WORD_BYTES);
        rsp.granted_index = grant[IDX_W-1:0];
        rsp.data_offset   = OFF_W'(grant * stride + 32'(WORD_BYTES));
      end
    end else if (CNT_W'(req.block_index) >= pool_n) begin
      rsp.status = ST_RANGE;
    end else begin
      links[req.block_index] = head;
      head = CNT_W'(req.block_index);
    end
    return rsp;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("[%0t] grant mismatch, %s: got %0d, expected %0d", $time, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    fbfl_rsp_t want;
    fbfl_rsp_t pred;
    if (!rst_n) begin
      pool_n     = clip_count(RST_BLOCK_COUNT);
      head       = NIL_CODE;
      fresh_left = pool_n;
      blk_bytes  = RST_BLOCK_BYTES;
      grant_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (grant_q.size() == 0) begin
          report_mismatch("response word with none outstanding", 32'(out_data.status), 0);
        end else begin
          want = grant_q.pop_front();
          if (out_data.status != want.status)
            report_mismatch("status", 32'(out_data.status), 32'(want.status));
          if (out_data.granted_index != want.granted_index)
            report_mismatch("granted_index", 32'(out_data.granted_index),
                            32'(want.granted_index));
          if (out_data.data_offset != want.data_offset)
            report_mismatch("data_offset", 32'(out_data.data_offset),
                            32'(want.data_offset));
        end
      end
      if (in_valid && in_ready) begin
        pred = next_grant(in_data);
        grant_q.push_back(pred);
        if (pred.status == ST_EMPTY) empties++;
        else if (pred.status == ST_RANGE) rejects++;
        else if (in_data.action == ACT_ALLOC) grants++;
        else frees++;
      end
      if (psel && penable && pwrite && pready) begin
        if (paddr[APB_AW-1:2] == REG_BLOCK_COUNT) begin
          pool_n     = clip_count(pwdata[CNT_W-1:0]);
          head       = NIL_CODE;
          fresh_left = pool_n;
        end else if (paddr[APB_AW-1:2] == REG_BLOCK_BYTES) begin
          blk_bytes = pwdata[BYTES_W-1:0];
        end
      end
    end
    pending <= grant_q.size();
  end

endmodule

FILE: verif/tb.sv
// Top of the allocator testbench: clock, reset, request and APB stimulus,
// random response stalls, and the verdict. Depends on fbfl_pkg, the
// allocator and fbfl_grant_checker.
module tb;
  import fbfl_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_ready;
  fbfl_req_t         in_data   = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  fbfl_rsp_t         out_data;
  logic              psel      = 1'b0;
  logic              penable   = 1'b0;
  logic              pwrite    = 1'b0;
  logic [APB_AW-1:0] paddr     = '0;
  logic [APB_DW-1:0] pwdata    = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  int fail_count;
  int pending_words;
  int grants;
  int empties;
  int rejects;
  int frees;

  int               cycles     = 0;
  int               next_gap   = 1;
  int               stall_left = 0;
  int               n_settings = 0;
  bit               gaps_on    = 1'b1;
  bit               stalls_on  = 1'b1;
  logic [CNT_W-1:0] pool_n     = RST_BLOCK_COUNT;

  fixed_block_free_list_allocator i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  fbfl_grant_checker i_grant_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .pready     (pready),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .fail_count (fail_count),
    .pending    (pending_words),
    .grants     (grants),
    .empties    (empties),
    .rejects    (rejects),
    .frees      (frees)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("cycle limit reached with %0d words outstanding", pending_words);
      $display("FAILURE");
      $finish;
    end
  end

  function automatic int pick_idle();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(6, 25);
  endfunction

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if (stalls_on) stall_left = pick_idle();
    end
  end

  task automatic send_word(input logic act, input logic [IDX_W-1:0] idx);
    fbfl_req_t w;
    w.action      = act;
    w.block_index = idx;
    if (next_gap > 0) repeat (next_gap) @(posedge clk);
    in_data  <= w;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    next_gap = gaps_on ? pick_idle() : 0;
    if (next_gap > 0) in_valid <= 1'b0;
  endtask

  // drop valid and let every outstanding word drain
  task automatic wait_idle();
    if (next_gap == 0) begin
      in_valid <= 1'b0;
      next_gap = 1;
    end
    @(posedge clk);
    while (pending_words != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic reg_write(input logic which, input logic [APB_DW-1:0] value);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {which, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    if (which == REG_BLOCK_COUNT)
      pool_n = (value[CNT_W-1:0] > CNT_W'(INDEX_LIMIT)) ? CNT_W'(INDEX_LIMIT)
                                                        : value[CNT_W-1:0];
    n_settings++;
  endtask

  task automatic random_word();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50)
      send_word(ACT_ALLOC, IDX_W'($urandom));
    else if (r < 90 && pool_n != '0)
      send_word(ACT_FREE, IDX_W'($urandom_range(0, int'(pool_n) - 1)));
    else
      send_word(ACT_FREE, IDX_W'($urandom));
  endtask

  function automatic logic [APB_DW-1:0] pick_bytes();
    case ($urandom_range(0, 4))
      0:       return 0;
      1:       return 8191;
      2:       return 4096;
      3:       return $urandom_range(1, 64);
      default: return $urandom_range(0, 8191);
    endcase
  endfunction

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // reset pool: fresh blocks from the top, then pops from the free list
    send_word(ACT_ALLOC, '0);
    send_word(ACT_ALLOC, '1);
    send_word(ACT_FREE, 10'd1023);
    send_word(ACT_FREE, 10'd0);
    send_word(ACT_ALLOC, 10'd0);
    send_word(ACT_ALLOC, 10'd0);
    send_word(ACT_ALLOC, 10'd0);
    send_word(ACT_FREE, 10'd1022);
    wait_idle();

    // empty pool
    reg_write(REG_BLOCK_COUNT, 0);
    send_word(ACT_ALLOC, '0);
    send_word(ACT_FREE, 10'd0);
    send_word(ACT_FREE, 10'd1023);
    wait_idle();

    // one block, zero payload
    reg_write(REG_BLOCK_COUNT, 1);
    reg_write(REG_BLOCK_BYTES, 0);
    send_word(ACT_ALLOC, '0);
    send_word(ACT_ALLOC, '0);
    send_word(ACT_FREE, 10'd0);
    send_word(ACT_FREE, 10'd1);
    send_word(ACT_ALLOC, '0);
    wait_idle();

    // oversize count and largest payload: top block wraps the offset
    reg_write(REG_BLOCK_COUNT, 2047);
    reg_write(REG_BLOCK_BYTES, 8191);
    send_word(ACT_ALLOC, '0);
    send_word(ACT_ALLOC, '0);
    send_word(ACT_FREE, 10'd1023);
    send_word(ACT_FREE, 10'd1022);
    wait_idle();

    // size change keeps the free list
    reg_write(REG_BLOCK_BYTES, 1);
    send_word(ACT_ALLOC, '0);
    send_word(ACT_ALLOC, '0);
    wait_idle();

    for (int p = 0; p < 10; p++) begin
      case (p % 5)
        0:       reg_write(REG_BLOCK_COUNT, $urandom_range(1, 8));
        1:       reg_write(REG_BLOCK_COUNT, $urandom_range(9, 64));
        2:       reg_write(REG_BLOCK_COUNT, (p < 5) ? 1024 : $urandom_range(1025, 2047));
        3:       reg_write(REG_BLOCK_COUNT, $urandom_range(0, 3));
        default: ;
      endcase
      reg_write(REG_BLOCK_BYTES, pick_bytes());
      gaps_on   = (p % 3 != 0);
      stalls_on = (p % 4 != 1);
      repeat (80) random_word();
      wait_idle();
    end

    $display("covered %0d requests across %0d register writes",
             grants + empties + rejects + frees, n_settings);
    $display("%0d grants, %0d pool-empty, %0d out-of-range frees, %0d frees accepted",
             grants, empties, rejects, frees);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
